/* sv/tesf_pkg.sv */
package tesf_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = 8;
  localparam int NUM_EVENTS  = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [NUM_EVENTS-1:0]  event_mask_t;

  typedef enum logic [2:0] {
    EV_FRONT = 3'd0,
    EV_BACK  = 3'd1,
    EV_LEFT  = 3'd2,
    EV_RIGHT = 3'd3,
    EV_DOWN  = 3'd4,
    EV_UP    = 3'd5,
    EV_TAP   = 3'd6,
    EV_SHAKE = 3'd7
  } event_t;

  localparam logic [2:0] CFG_FB_EN     = 3'd0;
  localparam logic [2:0] CFG_OR_EN     = 3'd1;
  localparam logic [2:0] CFG_TAP_EN    = 3'd2;
  localparam logic [2:0] CFG_RATE      = 3'd3;
  localparam logic [2:0] CFG_WINDOW    = 3'd4;
  localparam logic [2:0] CFG_HOLDOFF   = 3'd5;

  localparam logic [1:0] FB_FRONT = 2'b01;
  localparam logic [1:0] FB_BACK  = 2'b10;
  localparam logic [2:0] PL_LEFT  = 3'b001;
  localparam logic [2:0] PL_RIGHT = 3'b010;
  localparam logic [2:0] PL_DOWN  = 3'b101;
  localparam logic [2:0] PL_UP    = 3'b110;

  localparam logic [7:0] RATE_DIRECT = 8'd8;
  localparam logic [7:0] RATE_LOW    = 8'd64;
  localparam logic [7:0] RATE_HIGH   = 8'd128;

  localparam logic [3:0] THRESH_RESET = 4'd6;
  localparam logic [3:0] THRESH_LOW   = 4'd8;
  localparam logic [3:0] THRESH_HIGH  = 4'd15;

  localparam logic [7:0]  RATE_RESET    = 8'd120;
  localparam logic [15:0] WINDOW_RESET  = 16'd300;
  localparam logic [15:0] HOLDOFF_RESET = 16'd1000;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic        push;
    event_mask_t mask;
  } q_push_t;

  typedef struct packed {
    logic        valid;
    event_mask_t mask;
  } q_head_t;

endpackage

/* sv/tesf_front.sv */
module tesf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 acc,
  input  logic                 kind,
  input  tesf_pkg::time_t      time_ms,
  input  logic [1:0]           front_back,
  input  logic [2:0]           portrait_landscape,
  input  logic                 tap_flag,
  input  logic                 shake_flag,
  output tesf_pkg::q_push_t    q_push
);
  import tesf_pkg::*;

  logic        fb_en_r, or_en_r, tap_en_r;
  logic [7:0]  rate_r;
  logic [15:0] window_r, holdoff_r;

  logic [1:0] last_fb_r, last_fb_nxt;
  logic [2:0] last_pl_r, last_pl_nxt;
  count_t     count_r, count_nxt;
  logic [3:0] thresh_r, thresh_nxt;
  time_t      start_r, start_nxt;
  time_t      last_shake_r, last_shake_nxt;

  event_mask_t mask;
  time_t       since_shake, since_start;
  logic        in_holdoff, expired;
  count_t      count_tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_en_r   <= 1'b0;
      or_en_r   <= 1'b0;
      tap_en_r  <= 1'b0;
      rate_r    <= RATE_RESET;
      window_r  <= WINDOW_RESET;
      holdoff_r <= HOLDOFF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FB_EN:   fb_en_r   <= cfg_data[0];
        CFG_OR_EN:   or_en_r   <= cfg_data[0];
        CFG_TAP_EN:  tap_en_r  <= cfg_data[0];
        CFG_RATE:    rate_r    <= cfg_data[7:0];
        CFG_WINDOW:  window_r  <= cfg_data;
        CFG_HOLDOFF: holdoff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign since_shake = time_ms - last_shake_r;
  assign since_start = time_ms - start_r;
  assign in_holdoff  = since_shake < time_t'(holdoff_r);
  assign count_tick  = in_holdoff ? '0 : count_r;
  assign expired     = (count_tick != '0) && (since_start > time_t'(window_r));

  always_comb begin
    mask           = '0;
    last_fb_nxt    = last_fb_r;
    last_pl_nxt    = last_pl_r;
    count_nxt      = count_r;
    thresh_nxt     = thresh_r;
    start_nxt      = start_r;
    last_shake_nxt = last_shake_r;
    if (kind) begin
      count_nxt = count_tick;
      if (expired) begin
        if (count_tick >= count_t'(thresh_r)) begin
          mask[EV_SHAKE] = 1'b1;
          last_shake_nxt = time_ms;
        end
        count_nxt = '0;
      end
    end else begin
      if (fb_en_r && front_back != last_fb_r) begin
        mask[EV_FRONT] = (front_back == FB_FRONT);
        mask[EV_BACK]  = (front_back == FB_BACK);
      end
      if (or_en_r && portrait_landscape != last_pl_r) begin
        mask[EV_LEFT]  = (portrait_landscape == PL_LEFT);
        mask[EV_RIGHT] = (portrait_landscape == PL_RIGHT);
        mask[EV_DOWN]  = (portrait_landscape == PL_DOWN);
        mask[EV_UP]    = (portrait_landscape == PL_UP);
      end
      mask[EV_TAP] = tap_en_r && tap_flag;
      if (shake_flag) begin
        if (count_r != '0) begin
          if (count_r < COUNT_MAX) count_nxt = count_r + count_t'(1);
        end else if (rate_r <= RATE_DIRECT) begin
          mask[EV_SHAKE] = 1'b1;
        end else if (rate_r <= RATE_LOW) begin
          thresh_nxt = THRESH_LOW;
          count_nxt  = count_t'(1);
          start_nxt  = time_ms;
        end else if (rate_r <= RATE_HIGH) begin
          thresh_nxt = THRESH_HIGH;
          count_nxt  = count_t'(1);
          start_nxt  = time_ms;
        end
      end
      last_fb_nxt = front_back;
      last_pl_nxt = portrait_landscape;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_fb_r    <= '0;
      last_pl_r    <= '0;
      count_r      <= '0;
      thresh_r     <= THRESH_RESET;
      start_r      <= '0;
      last_shake_r <= '0;
    end else if (acc) begin
      last_fb_r    <= last_fb_nxt;
      last_pl_r    <= last_pl_nxt;
      count_r      <= count_nxt;
      thresh_r     <= thresh_nxt;
      start_r      <= start_nxt;
      last_shake_r <= last_shake_nxt;
    end
  end

  assign q_push.push = acc && (mask != '0);
  assign q_push.mask = mask;

endmodule

/* sv/tesf_queue.sv */
module tesf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tesf_pkg::q_push_t    q_push,
  input  logic                 pop,
  output tesf_pkg::q_head_t    q_head,
  output logic                 full
);
  import tesf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  event_mask_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign do_push = q_push.push && !full;
  assign do_pop  = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= q_push.mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.mask  = mem[rd_ptr_r];

endmodule

/* sv/tesf_back.sv */
module tesf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tesf_pkg::q_head_t  q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_event_res,
  output logic               out_last
);
  import tesf_pkg::*;

  event_mask_t cur_r, cur_nxt, rest;
  logic [2:0]  first_ev;

  always_comb begin
    first_ev = 3'd0;
    for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
      if (cur_r[i]) first_ev = 3'(i);
    end
  end

  // clear the lowest set bit
  assign rest = cur_r & (cur_r - event_mask_t'(1));

  always_comb begin
    cur_nxt = (out_valid && out_ready) ? rest : cur_r;
    pop     = (cur_nxt == '0) && q_head.valid;
    if (pop) cur_nxt = q_head.mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cur_r <= '0;
    else        cur_r <= cur_nxt;
  end

  assign out_valid     = (cur_r != '0);
  assign out_event_res = first_ev;
  assign out_last      = (rest == '0);

endmodule

/* sv/tilt_event_shake_filter.sv */
// Path: an accepted input's events enter the event queue, then the output register.
// Throughput: one input item per cycle while the two-entry event queue has room;
// the output side sends one event per cycle while out_ready is high, each report in full.
// Items that cause no event only update state.
// Reset: synchronous, active-low rst_n clears all state and restores register defaults.
module tilt_event_shake_filter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  tesf_pkg::time_t       in_time_ms,
  input  logic [1:0]            in_front_back,
  input  logic [2:0]            in_portrait_landscape,
  input  logic                  in_tap_flag,
  input  logic                  in_shake_flag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_event_res,
  output logic                  out_last
);
  import tesf_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full, q_pop, acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;

  tesf_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .acc                (acc),
    .kind               (in_kind),
    .time_ms            (in_time_ms),
    .front_back         (in_front_back),
    .portrait_landscape (in_portrait_landscape),
    .tap_flag           (in_tap_flag),
    .shake_flag         (in_shake_flag),
    .q_push             (q_push)
  );

  tesf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .q_head (q_head),
    .full   (q_full)
  );

  tesf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .out_last      (out_last)
  );

endmodule

/* sim/tb.sv */
module tb;
  import tesf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  class event_ledger;
    typedef struct {
      event_t ev;
      logic   last;
    } due_event_t;

    logic        fb_en, or_en, tap_en;
    logic [7:0]  rate;
    logic [15:0] window, holdoff;
    logic [1:0]  prev_fb;
    logic [2:0]  prev_pl;
    count_t      shakes;
    logic [3:0]  threshold;
    time_t       start_ms, shake_ms;
    due_event_t  due[$];
    int          mismatches;

    function new();
      fb_en      = 1'b0;
      or_en      = 1'b0;
      tap_en     = 1'b0;
      rate       = RATE_RESET;
      window     = WINDOW_RESET;
      holdoff    = HOLDOFF_RESET;
      prev_fb    = '0;
      prev_pl    = '0;
      shakes     = '0;
      threshold  = THRESH_RESET;
      start_ms   = '0;
      shake_ms   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_FB_EN:   fb_en = data[0];
        CFG_OR_EN:   or_en = data[0];
        CFG_TAP_EN:  tap_en = data[0];
        CFG_RATE:    rate = data[7:0];
        CFG_WINDOW:  window = data;
        CFG_HOLDOFF: holdoff = data;
        default: ;
      endcase
    endfunction

    function void note_transfer(logic kind, time_t t, logic [1:0] fb, logic [2:0] pl,
                                logic tap, logic shake);
      event_t     evs[$];
      time_t      since_shake;
      time_t      elapsed;
      due_event_t entry;
      if (kind) begin
        since_shake = t - shake_ms;
        elapsed = t - start_ms;
        if (since_shake < holdoff) shakes = '0;
        if (shakes != '0 && elapsed > window) begin
          if (shakes >= threshold) begin
            evs.push_back(EV_SHAKE);
            shake_ms = t;
          end
          shakes = '0;
        end
      end else begin
        if (fb_en && fb != prev_fb) begin
          if (fb == FB_FRONT) evs.push_back(EV_FRONT);
          else if (fb == FB_BACK) evs.push_back(EV_BACK);
        end
        if (or_en && pl != prev_pl) begin
          case (pl)
            PL_LEFT:  evs.push_back(EV_LEFT);
            PL_RIGHT: evs.push_back(EV_RIGHT);
            PL_DOWN:  evs.push_back(EV_DOWN);
            PL_UP:    evs.push_back(EV_UP);
            default: ;
          endcase
        end
        if (tap_en && tap) evs.push_back(EV_TAP);
        if (shake) begin
          if (shakes != '0) begin
            if (shakes != COUNT_MAX) shakes = shakes + count_t'(1);
          end else if (rate <= RATE_DIRECT) begin
            evs.push_back(EV_SHAKE);
          end else if (rate <= RATE_LOW) begin
            threshold = THRESH_LOW;
            shakes = count_t'(1);
            start_ms = t;
          end else if (rate <= RATE_HIGH) begin
            threshold = THRESH_HIGH;
            shakes = count_t'(1);
            start_ms = t;
          end
        end
        prev_fb = fb;
        prev_pl = pl;
      end
      foreach (evs[i]) begin
        entry.ev = evs[i];
        entry.last = (i == evs.size() - 1);
        due.push_back(entry);
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_event(logic [2:0] ev, logic last);
      due_event_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d last %0b", ev, last));
      end else begin
        want = due.pop_front();
        if (ev !== want.ev)
          report_mismatch($sformatf("event %0d, wanted %s", ev, want.ev.name()));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b on %s", last, want.last,
                                    want.ev.name()));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  time_t       in_time_ms;
  logic [1:0]  in_front_back;
  logic [2:0]  in_portrait_landscape;
  logic        in_tap_flag;
  logic        in_shake_flag;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_event_res;
  logic        out_last;

  event_ledger sb;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int          items_sent;
  int          stall_count;

  tilt_event_shake_filter u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_time_ms            (in_time_ms),
    .in_front_back         (in_front_back),
    .in_portrait_landscape (in_portrait_landscape),
    .in_tap_flag           (in_tap_flag),
    .in_shake_flag         (in_shake_flag),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_event_res         (out_event_res),
    .out_last              (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        sb.note_transfer(in_kind, in_time_ms, in_front_back, in_portrait_landscape,
                         in_tap_flag, in_shake_flag);
      if (out_valid && out_ready) sb.check_event(out_event_res, out_last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // receiver: random back-pressure, plus one long hold-off to fill the block
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(logic fb, logic orient, logic tap, logic [7:0] rate,
                                logic [15:0] window, logic [15:0] holdoff);
    cfg_write(CFG_FB_EN, 16'(fb));
    cfg_write(CFG_OR_EN, 16'(orient));
    cfg_write(CFG_TAP_EN, 16'(tap));
    cfg_write(CFG_RATE, 16'(rate));
    cfg_write(CFG_WINDOW, window);
    cfg_write(CFG_HOLDOFF, holdoff);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic kind, time_t t, logic [1:0] fb, logic [2:0] pl,
                           logic tap, logic shake);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 15);
    end
    in_valid              <= 1'b1;
    in_kind               <= kind;
    in_time_ms            <= t;
    in_front_back         <= fb;
    in_portrait_landscape <= pl;
    in_tap_flag           <= tap;
    in_shake_flag         <= shake;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // settle before touching registers; event-free items may still be in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(int n, time_t start);
    int    stop;
    int    pick;
    int    k;
    int    step;
    time_t now;
    time_t burst_start;
    stop = items_sent + n;
    now = start;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // shake burst inside one window, then ticks around its expiry
        k = $urandom_range(1, 18);
        step = sb.window / k;
        burst_start = now;
        repeat (k) begin
          send_item(1'b0, now, 2'($urandom_range(3)), 3'($urandom_range(7)),
                    1'($urandom_range(1)), $urandom_range(99) < 90);
          now += $urandom_range(0, step);
        end
        if ($urandom_range(1))
          send_item(1'b1, now, 2'($urandom_range(3)), 3'($urandom_range(7)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        now = burst_start + sb.window + $urandom_range(0, 2);
        send_item(1'b1, now, 2'($urandom_range(3)), 3'($urandom_range(7)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        now += $urandom_range(0, 2 * sb.holdoff + 20);
      end else if (pick < 78) begin
        now += $urandom_range(0, 50);
        send_item(1'b0, now, 2'($urandom_range(3)), 3'($urandom_range(7)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        now += $urandom_range(0, 2 * sb.window + 10);
        send_item(1'b1, now, 2'($urandom_range(3)), 3'($urandom_range(7)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        now = $urandom;
        send_item(1'($urandom_range(1)), now, 2'($urandom_range(3)),
                  3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // enough shakes in one window to saturate the counter
  task automatic saturate_count();
    time_t now;
    time_t t0;
    now = $urandom;
    t0 = now;
    repeat (258) begin
      send_item(1'b0, now, 2'($urandom_range(3)), 3'($urandom_range(7)),
                1'($urandom_range(1)), 1'b1);
      now += $urandom_range(0, 200);
    end
    send_item(1'b1, t0 + 32'd65535, 2'($urandom_range(3)), 3'($urandom_range(7)),
              1'b0, 1'b0);
    send_item(1'b1, t0 + 32'd65536, 2'($urandom_range(3)), 3'($urandom_range(7)),
              1'b1, 1'b1);
    send_item(1'b0, t0 + 32'd65537, 2'($urandom_range(3)), 3'($urandom_range(7)),
              1'b1, 1'b1);
    send_item(1'b1, t0 + 32'd65537, 2'($urandom_range(3)), 3'($urandom_range(7)),
              1'b0, 1'b0);
  endtask

  initial begin
    sb = new();
    quiet      = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    rst_n                 <= 1'b0;
    cfg_valid             <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    in_valid              <= 1'b0;
    in_kind               <= 1'b0;
    in_time_ms            <= '0;
    in_front_back         <= '0;
    in_portrait_landscape <= '0;
    in_tap_flag           <= 1'b0;
    in_shake_flag         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // code changes, invalid codes, tap, direct shake, four events at once, tick fields
    apply_settings(1'b1, 1'b1, 1'b1, RATE_DIRECT, WINDOW_RESET, HOLDOFF_RESET);
    send_item(1'b0, 32'd5000, FB_FRONT, PL_LEFT, 1'b0, 1'b0);
    send_item(1'b0, 32'd5001, FB_BACK, PL_RIGHT, 1'b0, 1'b0);
    send_item(1'b0, 32'd5002, 2'b00, PL_DOWN, 1'b0, 1'b0);
    send_item(1'b0, 32'd5003, 2'b11, PL_UP, 1'b1, 1'b0);
    send_item(1'b0, 32'd5004, 2'b11, PL_UP, 1'b0, 1'b0);
    send_item(1'b0, 32'd5005, FB_FRONT, 3'b011, 1'b0, 1'b1);
    send_item(1'b0, 32'd5006, FB_BACK, PL_LEFT, 1'b1, 1'b1);
    send_item(1'b0, 32'd5007, FB_BACK, 3'b100, 1'b0, 1'b0);
    send_item(1'b0, 32'd5008, FB_BACK, 3'b111, 1'b0, 1'b0);
    send_item(1'b0, 32'd5009, FB_BACK, 3'b000, 1'b0, 1'b0);
    send_item(1'b1, 32'd5010, 2'b11, 3'b111, 1'b1, 1'b1);

    // counting window: threshold reached, boundary of expiry, window below threshold
    wait_drained();
    apply_settings(1'b1, 1'b1, 1'b1, RATE_DIRECT + 8'd1, 16'd0, 16'd0);
    repeat (8) send_item(1'b0, 32'd10000, FB_BACK, PL_LEFT, 1'b0, 1'b1);
    send_item(1'b1, 32'd10000, FB_BACK, PL_LEFT, 1'b0, 1'b0);
    send_item(1'b1, 32'd10001, FB_BACK, PL_LEFT, 1'b0, 1'b0);
    send_item(1'b0, 32'd10002, FB_BACK, PL_LEFT, 1'b0, 1'b1);
    send_item(1'b1, 32'd10003, FB_BACK, PL_LEFT, 1'b0, 1'b0);

    wait_drained();
    apply_settings(1'b1, 1'b1, 1'b1, 8'd255, 16'hFFFF, 16'hFFFF);
    hold_req = 1'b1;
    run_phase(6, $urandom);

    wait_drained();
    apply_settings(1'b0, 1'b0, 1'b0, 8'd1, 16'd0, 16'd0);
    run_phase(6, $urandom);

    wait_drained();
    apply_settings(1'b1, 1'b0, 1'b1, RATE_LOW, 16'($urandom_range(0, 500)),
                   16'($urandom_range(0, 1500)));
    run_phase(6, $urandom);

    wait_drained();
    apply_settings(1'b0, 1'b1, 1'b0, RATE_HIGH, 16'($urandom_range(0, 500)),
                   16'($urandom_range(0, 1500)));
    run_phase(6, 32'hFFFF_FF00);

    wait_drained();
    apply_settings(1'b1, 1'b1, 1'b1, RATE_LOW + 8'd1, 16'($urandom_range(0, 1000)),
                   16'($urandom_range(0, 2000)));
    run_phase(6, $urandom);

    wait_drained();
    apply_settings(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
    run_phase(6, $urandom);

    wait_drained();
    apply_settings(1'b1, 1'b1, 1'b1, 8'($urandom_range(9, 128)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
    run_phase(6, $urandom);

    wait_drained();
    apply_settings(1'b1, 1'b1, 1'b0, RATE_RESET, WINDOW_RESET, HOLDOFF_RESET);
    run_phase(6, $urandom);

    wait_drained();
    apply_settings(1'b0, 1'b0, 1'b1, RATE_LOW, 16'hFFFF, 16'd0);
    quiet = 1'b1;
    saturate_count();
    quiet = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
